>>> src/srtc_pkg.sv
// Shared constants, types and functions of the serial relay and tap commander.
package srtc_pkg;

  localparam int LINE_MAX = 128;
  localparam int LEN_W = 8;
  localparam int PAT_W = 14;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [7:0] NL_BYTE = 8'd10;
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_1 = 8'h31;
  localparam logic [7:0] CH_2 = 8'h32;
  localparam logic [7:0] CH_5 = 8'h35;
  localparam logic [7:0] CH_6 = 8'h36;
  localparam logic [7:0] CH_7 = 8'h37;
  localparam logic [7:0] CH_8 = 8'h38;
  localparam logic [7:0] CH_M = 8'h4D;

  localparam logic [3:0] CODE_NONE = 4'd0;
  localparam logic [3:0] CODE_RELAY_LAST = 4'd12;
  localparam logic [3:0] CODE_M0 = 4'd13;
  localparam logic [3:0] CODE_M1 = 4'd14;
  localparam logic [3:0] CODE_NOT_FOUND = 4'd15;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_PULSE_TICKS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_POSITION_MAX = CFG_IDX_W'(1);

  localparam logic [15:0] PULSE_TICKS_RST = 16'd100;
  localparam logic [7:0] POSITION_MAX_RST = 8'd90;

  typedef enum logic [2:0] {
    DIR_NONE = 3'b001,
    DIR_DOWN = 3'b010,
    DIR_UP   = 3'b100
  } dir_t;

  typedef struct packed {
    logic byte_en;
    logic line_end;
  } line_ctrl_t;

  // Relay slot for the third character of a relay pattern; bit 3 flags a hit.
  function automatic logic [3:0] relay_slot(input logic [7:0] c);
    logic [3:0] s;
    case (c)
      CH_1: s = 4'b1000;
      CH_2: s = 4'b1001;
      CH_5: s = 4'b1010;
      CH_6: s = 4'b1011;
      CH_7: s = 4'b1100;
      CH_8: s = 4'b1101;
      default: s = 4'b0000;
    endcase
    return s;
  endfunction

  // Lowest set pattern bit wins.
  function automatic logic [3:0] first_code(input logic [PAT_W-1:0] pat);
    logic [3:0] code;
    code = CODE_NOT_FOUND;
    for (int k = PAT_W - 1; k >= 0; k--) begin
      if (pat[k]) begin
        code = 4'(k + 1);
      end
    end
    return code;
  endfunction

endpackage

>>> src/srtc_if.sv
// Request channel interfaces: input, result and configuration write.
interface srtc_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;
  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

interface srtc_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] relays;
  logic       lower_drive;
  logic       raise_drive;
  logic [7:0] tap_position;
  logic [3:0] command_code;
  modport source (output valid, output relays, output lower_drive, output raise_drive,
                  output tap_position, output command_code, input ready);
  modport sink (input valid, input relays, input lower_drive, input raise_drive,
                input tap_position, input command_code, output ready);
endinterface

interface srtc_cfg_if;
  import srtc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/srtc_line.sv
// Line scanner: two-byte window, length count and pattern flags of the current line.
module srtc_line (
  input  logic                       clk,
  input  logic                       rst_n,
  input  srtc_pkg::line_ctrl_t       ctrl,
  input  logic [7:0]                 rx_byte,
  output logic [srtc_pkg::PAT_W-1:0] pattern
);
  import srtc_pkg::*;

  logic [7:0]       last_r, last_nxt;
  logic [7:0]       second_r, second_nxt;
  logic [PAT_W-1:0] pat_r, pat_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             term_r, term_nxt;
  logic [3:0]       slot;
  logic [3:0]       bit_idx;

  always_comb begin
    last_nxt   = last_r;
    second_nxt = second_r;
    pat_nxt    = pat_r;
    len_nxt    = len_r;
    term_nxt   = term_r;
    slot       = relay_slot(rx_byte);
    bit_idx    = {slot[2:0], (second_r == CH_1)};
    if (ctrl.line_end) begin
      last_nxt   = '0;
      second_nxt = '0;
      pat_nxt    = '0;
      len_nxt    = '0;
      term_nxt   = 1'b0;
    end else if (ctrl.byte_en && (len_r < LEN_W'(LINE_MAX))) begin
      len_nxt = len_r + LEN_W'(1);
      if (!term_r) begin
        if (rx_byte == 8'd0) begin
          term_nxt = 1'b1;
        end else begin
          if (slot[3] && (last_r == CH_0) && ((second_r == CH_0) || (second_r == CH_1))) begin
            pat_nxt[bit_idx] = 1'b1;
          end
          if ((last_r == CH_M) && (rx_byte == CH_0)) begin
            pat_nxt[CODE_M0 - 4'd1] = 1'b1;
          end
          if ((last_r == CH_M) && (rx_byte == CH_1)) begin
            pat_nxt[CODE_M1 - 4'd1] = 1'b1;
          end
          second_nxt = last_r;
          last_nxt   = rx_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r   <= '0;
      second_r <= '0;
      pat_r    <= '0;
      len_r    <= '0;
      term_r   <= 1'b0;
    end else begin
      last_r   <= last_nxt;
      second_r <= second_nxt;
      pat_r    <= pat_nxt;
      len_r    <= len_nxt;
      term_r   <= term_nxt;
    end
  end

  assign pattern = pat_r;

endmodule

>>> src/serial_relay_tap_commander.sv
// Serial relay and tap commander top level.
// Each request is either a received byte (operation 0) or a time tick (operation 1), and every
// request yields exactly one result: relay bits, lower/raise drive, tap position and a command
// code. A request goes through the state update into the result register, so one request is
// accepted per clock while the result register is empty or being drained. Byte 10 ends a line
// and acts on the pattern with the lowest code seen in it (relay 00x/10x, then M0, then M1).
// Ticks time the tap move pulse of pulse_ticks ticks; the position changes as the pulse ends.
// Configuration writes are always accepted and should be issued only while the block is idle.
module serial_relay_tap_commander (
  input logic        clk,
  input logic        rst_n,
  srtc_in_if.sink    in_ch,
  srtc_out_if.source out_ch,
  srtc_cfg_if.sink   cfg_ch
);
  import srtc_pkg::*;

  logic [15:0] pulse_ticks_r;
  logic [7:0]  position_max_r;

  logic [5:0]  relay_r, relay_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic        down_pend_r, down_pend_nxt;
  logic        up_pend_r, up_pend_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] rem_dec;
  dir_t        dir_r, dir_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [5:0]  out_relays_r;
  logic        out_lower_r;
  logic        out_raise_r;
  logic [7:0]  out_pos_r;
  logic [3:0]  out_code_r;
  logic [3:0]  code_nxt;
  logic [3:0]  line_code;
  logic [2:0]  relay_bit;

  logic             in_acc;
  line_ctrl_t       line_ctrl;
  logic [PAT_W-1:0] pattern;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign line_ctrl.line_end = in_acc && (in_ch.operation == OP_BYTE) && (in_ch.rx_byte == NL_BYTE);
  assign line_ctrl.byte_en  = in_acc && (in_ch.operation == OP_BYTE) && (in_ch.rx_byte != NL_BYTE);

  srtc_line u_line (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (line_ctrl),
    .rx_byte (in_ch.rx_byte),
    .pattern (pattern)
  );

  assign line_code = first_code(pattern);
  assign relay_bit = 3'((line_code - 4'd1) >> 1);
  assign rem_dec   = rem_r - {15'd0, (rem_r != 16'd0)};

  always_comb begin
    relay_nxt     = relay_r;
    pos_nxt       = pos_r;
    down_pend_nxt = down_pend_r;
    up_pend_nxt   = up_pend_r;
    rem_nxt       = rem_r;
    dir_nxt       = dir_r;
    code_nxt      = CODE_NONE;
    if (in_acc && (in_ch.operation == OP_TICK)) begin
      if (dir_r != DIR_NONE) begin
        rem_nxt = rem_dec;
        if (rem_dec == 16'd0) begin
          if (dir_r == DIR_DOWN) begin
            if (pos_r != 8'd0) pos_nxt = pos_r - 8'd1;
            down_pend_nxt = 1'b0;
          end else begin
            if (pos_r < position_max_r) pos_nxt = pos_r + 8'd1;
            up_pend_nxt = 1'b0;
          end
          dir_nxt = DIR_NONE;
        end
      end else if (down_pend_r && (pos_r != 8'd0)) begin
        dir_nxt = DIR_DOWN;
        rem_nxt = (pulse_ticks_r != 16'd0) ? pulse_ticks_r : 16'd1;
      end else if (up_pend_r && (pos_r < position_max_r)) begin
        dir_nxt = DIR_UP;
        rem_nxt = (pulse_ticks_r != 16'd0) ? pulse_ticks_r : 16'd1;
      end
    end else if (line_ctrl.line_end) begin
      code_nxt = line_code;
      if (line_code <= CODE_RELAY_LAST) begin
        relay_nxt[relay_bit] = !line_code[0];
      end else if (line_code == CODE_M0) begin
        if (pos_r != 8'd0) down_pend_nxt = 1'b1;
      end else if (line_code == CODE_M1) begin
        if (pos_r < position_max_r) up_pend_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_ticks_r  <= PULSE_TICKS_RST;
      position_max_r <= POSITION_MAX_RST;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_PULSE_TICKS) begin
        pulse_ticks_r <= cfg_ch.data;
      end else if (cfg_ch.index == REG_POSITION_MAX) begin
        position_max_r <= cfg_ch.data[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relay_r     <= '0;
      pos_r       <= '0;
      down_pend_r <= 1'b0;
      up_pend_r   <= 1'b0;
      rem_r       <= '0;
      dir_r       <= DIR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      relay_r     <= relay_nxt;
      pos_r       <= pos_nxt;
      down_pend_r <= down_pend_nxt;
      up_pend_r   <= up_pend_nxt;
      rem_r       <= rem_nxt;
      dir_r       <= dir_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_relays_r <= relay_nxt;
      out_lower_r  <= (dir_nxt == DIR_DOWN);
      out_raise_r  <= (dir_nxt == DIR_UP);
      out_pos_r    <= pos_nxt;
      out_code_r   <= code_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.relays       = out_relays_r;
  assign out_ch.lower_drive  = out_lower_r;
  assign out_ch.raise_drive  = out_raise_r;
  assign out_ch.tap_position = out_pos_r;
  assign out_ch.command_code = out_code_r;

`ifndef SYNTH
  a_line_end_code: assert property (@(posedge clk) disable iff (!rst_n)
    line_ctrl.line_end |=> (out_valid_r && (out_code_r != CODE_NONE)))
    else $error("line end gave no command code");

  a_tick_no_code: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_ch.operation == OP_TICK)) |=> (out_valid_r && (out_code_r == CODE_NONE)))
    else $error("tick gave a command code");

  a_drive_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_lower_r && out_raise_r))
    else $error("both drives active");
`endif

endmodule
